// ===== design/sorted_matrix_staircase_search_top_assert.svh =====
// Assertion helpers for the staircase search block.
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_TOP_ASSERT_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/smss_pkg.sv =====
`default_nettype none

package smss_pkg;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ROW_COUNT = 4'd0;
    localparam t_cfg_idx CFG_COL_COUNT = 4'd1;

    localparam int COUNT_W = 7;
    typedef logic [COUNT_W-1:0] t_count;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [31:0] element_value;
        logic signed [31:0] search_key;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [5:0] found_row;
        logic [5:0] found_col;
    } t_rsp;

endpackage

`default_nettype wire

// ===== design/smss_ram.sv =====
`default_nettype none

module smss_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    parameter int AW    = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/sorted_matrix_staircase_search_top.sv =====
`default_nettype none

// Staircase search over a matrix whose rows and columns are sorted ascending.
// Request channel: a beat is taken when i_start is high and o_busy is low.
//   A load beat writes one element and completes in that cycle; o_busy stays
//   low and no result follows. A load outside MAX_ROWS x MAX_COLS is dropped.
//   A search beat starts a walk at the top-right cell of the region in use.
// Walk: one cell per cycle through the registered read of the matrix RAM,
//   then one signed compare picks left, down or hit. o_busy stays high
//   while the walk runs; on a miss the walk also steps onto the edge of
//   the region before it ends. Counts are clamped to the array size.
// Result channel: o_strobe is high for one cycle with o_rsp; the receiver
//   cannot stall it. The strobe is high in the first cycle with o_busy low,
//   and a new beat may be taken in that same cycle.
// Configuration: i_cfg_index / i_cfg_data with i_cfg_valid; o_cfg_ready is
//   always high. Write only while no search is in flight.
// Reset (synchronous, active low) returns to idle and sets both counts to 64.
//   Matrix contents are undefined until loaded.
module sorted_matrix_staircase_search_top
    import smss_pkg::*;
#(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    output logic          o_busy,
    input  wire t_req     i_req,
    output logic          o_strobe,
    output t_rsp          o_rsp,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_count   i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);

    typedef enum logic {ST_IDLE, ST_WALK} t_state;

    // Take the low DATA_WIDTH bits of a 32-bit field, zero filling above it
    function automatic logic [DATA_WIDTH-1:0] to_dw(input logic [31:0] v);
        logic [63:0] wide;
        wide = {32'b0, v};
        return wide[DATA_WIDTH-1:0];
    endfunction

    t_state                r_state;
    t_count                r_row_count;
    t_count                r_col_count;
    logic [DATA_WIDTH-1:0] r_key;
    logic [RCW-1:0]        r_row;
    logic [CCW-1:0]        r_colp;   // column plus one, zero is off the left
    logic                  r_strobe;
    t_rsp                  r_rsp;

    t_state                n_state;
    logic [RCW-1:0]        n_row;
    logic [CCW-1:0]        n_colp;
    logic                  n_strobe;
    t_rsp                  n_rsp;

    logic [RCW-1:0]        rows_lim;
    logic [CCW-1:0]        cols_lim;
    logic                  accept;
    logic                  load_we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] cur_elem;

    // Clamp counts to the array size
    always_comb begin
        if (32'(r_row_count) > MAX_ROWS) begin
            rows_lim = RCW'(MAX_ROWS);
        end else begin
            rows_lim = RCW'(r_row_count);
        end
        if (32'(r_col_count) > MAX_COLS) begin
            cols_lim = CCW'(MAX_COLS);
        end else begin
            cols_lim = CCW'(r_col_count);
        end
    end

    assign accept  = i_start && (r_state == ST_IDLE);
    assign load_we = accept && (i_req.req_type == REQ_LOAD)
                     && (32'(i_req.row_index) < MAX_ROWS)
                     && (32'(i_req.col_index) < MAX_COLS);
    assign waddr   = AW'(32'(i_req.row_index) * MAX_COLS + 32'(i_req.col_index));

    // Walk step: compare current cell, pick next position
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_colp   = r_colp;
        n_strobe = 1'b0;
        n_rsp    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_req.req_type == REQ_SEARCH)) begin
                    n_state = ST_WALK;
                    n_row   = '0;
                    n_colp  = cols_lim;
                end
            end
            ST_WALK: begin
                if ((r_row >= rows_lim) || (r_colp == '0)) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                end else if ($signed(cur_elem) > $signed(r_key)) begin
                    n_colp = r_colp - 1'b1;
                end else if ($signed(cur_elem) < $signed(r_key)) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_state         = ST_IDLE;
                    n_strobe        = 1'b1;
                    n_rsp.found     = 1'b1;
                    n_rsp.found_row = 6'(r_row);
                    n_rsp.found_col = 6'(r_colp - 1'b1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Read address follows the next position so one cell is read per cycle
    assign raddr = AW'(32'(n_row) * MAX_COLS + 32'(n_colp) - 1);

    // State, walk position, configuration and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_count <= t_count'(64);
            r_col_count <= t_count'(64);
            r_row       <= '0;
            r_colp      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_colp   <= n_colp;
            r_strobe <= n_strobe;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    CFG_COL_COUNT: r_col_count <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= to_dw(i_req.search_key);
        end
        if (n_strobe) begin
            r_rsp <= n_rsp;
        end
    end

    smss_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (waddr),
        .i_wdata (to_dw(i_req.element_value)),
        .i_raddr (raddr),
        .o_rdata (cur_elem)
    );

    assign o_busy      = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

`include "sorted_matrix_staircase_search_top_assert.svh"

    `SMSS_ASSERT_NOW(a_strobe_after_walk, i_clk, i_rst_n, o_strobe, $past(o_busy))
    `SMSS_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_strobe && !o_rsp.found,
        (o_rsp.found_row == 6'd0) && (o_rsp.found_col == 6'd0))
    `SMSS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n,
        i_start && !o_busy && (i_req.req_type == REQ_SEARCH), o_busy)
    `SMSS_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n,
        i_start && !o_busy && (i_req.req_type == REQ_LOAD), !o_strobe && !o_busy)

endmodule

`default_nettype wire
